### hw/rtl/aes_pkg.sv
// aes package: sbox tables, gf helpers, shared constants and types
// no dependencies
package aes_pkg;

    localparam int RkWords = 60;
    localparam int RkAw = $clog2(RkWords);
    // round key memory holds one round key (four words) per row
    localparam int RkRows = RkWords / 4;
    localparam int RkRowAw = $clog2(RkRows);

    localparam logic [1:0] KS_128 = 2'd0;
    localparam logic [1:0] KS_192 = 2'd1;
    localparam logic [1:0] KS_256 = 2'd2;

    localparam logic [2:0] CFG_KEY_SIZE = 3'd0;
    localparam logic [2:0] CFG_KEY_W0   = 3'd1;
    localparam logic [2:0] CFG_KEY_W3   = 3'd4;

    localparam logic [7:0] GF_POLY = 8'h1b;

    typedef logic [RkAw-1:0] t_rk_addr;
    typedef logic [RkRowAw-1:0] t_rk_row;

    typedef struct packed {
        logic     we;
        t_rk_addr addr;
        logic [31:0] data;
    } t_rk_wr;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
 8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
 8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
 8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
 8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
 8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
 8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
 8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
 8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
 8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
 8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
 8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
 8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
 8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
 8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
 8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
 8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[x];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
 8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
 8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
 8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
 8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
 8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
 8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
 8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
 8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
 8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
 8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
 8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
 8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
 8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
 8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
 8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
 8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        return t[x];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? GF_POLY : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

endpackage

### hw/rtl/aes_stream_if.sv
// valid/ready channel carrying an aes block or result
// no dependencies
interface aes_stream_if #(
    parameter int DataW = 129
);
    logic             valid;
    logic             ready;
    logic [DataW-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/aes_block_cipher_unit.sv
// aes top level: config registers, round key memory, round datapath
// depends on aes_pkg, aes_stream_if, aes_key_exp
// an accepted block passes S_FETCH, the S_ROUND steps and S_OUT before its result is registered
// a new block is accepted only in S_IDLE, after the previous result is loaded into the output register
// after a key write the first block also waits in S_EXPAND for the key expansion
// synchronous active-low reset; round key memory is not cleared
module aes_block_cipher_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_index,
    input  logic [63:0]   i_cfg_data,
    aes_stream_if.sink    s_in,
    aes_stream_if.source  m_out
);
    import aes_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_EXPAND, S_FETCH, S_ROUND, S_OUT} t_state;

    t_state       r_state;
    logic [1:0]   r_key_size;
    logic [63:0]  r_key [4];
    logic         r_keys_ready;
    logic [1:0]   eff_ks;
    logic         r_dec;
    logic [127:0] r_st;
    logic [3:0]   r_round;
    logic [3:0]   r_nr;
    logic         r_start;
    logic [127:0] r_out;
    logic         r_out_v;

    logic [127:0] r_mem [RkRows];
    t_rk_wr       kwr;
    logic         kdone;
    logic [127:0] r_rk;

    assign eff_ks = (r_key_size == 2'd3) ? KS_256 : r_key_size;

    aes_key_exp u_kexp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_start),
        .i_key_size (eff_ks),
        .i_key      ({r_key[0], r_key[1], r_key[2], r_key[3]}),
        .o_wr       (kwr),
        .o_done     (kdone)
    );

    // round function on full state
    logic [127:0] fwd_st, inv_st, sb, sr, mc, n_st;
    always_comb begin
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) begin
                sr[127 - 8*(4*c+r) -: 8] = sbox(r_st[127 - 8*(4*((c+r)&3)+r) -: 8]);
                sb[127 - 8*(4*((c+r)&3)+r) -: 8] = inv_sbox(r_st[127 - 8*(4*c+r) -: 8]);
            end
        for (int c = 0; c < 4; c++) begin
            logic [7:0] a, b, d, e, all, a2, b2, d2, e2, a4, b4, d4, e4, a8, b8, d8, e8;
            a = sr[127-32*c -: 8]; b = sr[119-32*c -: 8];
            d = sr[111-32*c -: 8]; e = sr[103-32*c -: 8];
            all = a ^ b ^ d ^ e;
            mc[127-32*c -: 8] = a ^ all ^ xtime(a ^ b);
            mc[119-32*c -: 8] = b ^ all ^ xtime(b ^ d);
            mc[111-32*c -: 8] = d ^ all ^ xtime(d ^ e);
            mc[103-32*c -: 8] = e ^ all ^ xtime(e ^ a);
            a = sb[127-32*c -: 8] ^ r_rk[127-32*c -: 8];
            b = sb[119-32*c -: 8] ^ r_rk[119-32*c -: 8];
            d = sb[111-32*c -: 8] ^ r_rk[111-32*c -: 8];
            e = sb[103-32*c -: 8] ^ r_rk[103-32*c -: 8];
            a2 = xtime(a); b2 = xtime(b); d2 = xtime(d); e2 = xtime(e);
            a4 = xtime(a2); b4 = xtime(b2); d4 = xtime(d2); e4 = xtime(e2);
            a8 = xtime(a4); b8 = xtime(b4); d8 = xtime(d4); e8 = xtime(e4);
            inv_st[127-32*c -: 8] = (a8^a4^a2) ^ (b8^b2^b) ^ (d8^d4^d) ^ (e8^e);
            inv_st[119-32*c -: 8] = (a8^a) ^ (b8^b4^b2) ^ (d8^d2^d) ^ (e8^e4^e);
            inv_st[111-32*c -: 8] = (a8^a4^a) ^ (b8^b) ^ (d8^d4^d2) ^ (e8^e2^e);
            inv_st[103-32*c -: 8] = (a8^a2^a) ^ (b8^b4^b) ^ (d8^d) ^ (e8^e4^e2);
        end
        fwd_st = mc ^ r_rk;
    end

    logic last;
    assign last = (r_round == r_nr);

    // step 0 is the initial key addition, step nr the final round
    always_comb begin
        if (r_round == 4'd0) begin
            n_st = r_st ^ r_rk;
        end else if (last) begin
            n_st = (r_dec ? sb : sr) ^ r_rk;
        end else begin
            n_st = r_dec ? inv_st : fwd_st;
        end
    end

    // round key row for the step applied in the next cycle
    logic [3:0] step_nxt;
    logic [3:0] key_round;
    t_rk_row    rd_row;
    always_comb begin
        step_nxt  = (r_state == S_FETCH) ? 4'd0 : r_round + 4'd1;
        key_round = r_dec ? (r_nr - step_nxt) : step_nxt;
        if (r_state == S_FETCH || (r_state == S_ROUND && !last)) begin
            rd_row = t_rk_row'(key_round);
        end else begin
            rd_row = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (kwr.we) r_mem[kwr.addr[RkAw-1:2]][127 - 32*kwr.addr[1:0] -: 32] <= kwr.data;
        r_rk <= r_mem[rd_row];
    end

    logic cfg_hit;
    logic expand_done;
    logic out_load;
    assign cfg_hit     = i_cfg_we && (i_cfg_index inside {[CFG_KEY_SIZE:CFG_KEY_W3]});
    assign expand_done = (r_state == S_EXPAND) && kdone && !r_start;
    assign out_load    = (r_state == S_OUT) && (!r_out_v || m_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_key_size   <= KS_128;
            for (int k = 0; k < 4; k++) r_key[k] <= '0;
            r_keys_ready <= 1'b0;
            r_start      <= 1'b0;
            r_out_v      <= 1'b0;
        end else begin
            r_start      <= 1'b0;
            r_out_v      <= out_load | (r_out_v & ~m_out.ready);
            r_keys_ready <= cfg_hit ? 1'b0 : (expand_done | r_keys_ready);
            if (out_load) r_out <= r_st;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_KEY_SIZE) begin
                    r_key_size <= i_cfg_data[1:0];
                end else if (i_cfg_index inside {[CFG_KEY_W0:CFG_KEY_W3]}) begin
                    r_key[2'(i_cfg_index - CFG_KEY_W0)] <= i_cfg_data;
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (s_in.valid) begin
                        r_dec   <= s_in.data[128];
                        r_st    <= s_in.data[127:0];
                        r_nr    <= 4'd10 + {1'b0, eff_ks, 1'b0};
                        r_round <= '0;
                        if (r_keys_ready) begin
                            r_state <= S_FETCH;
                        end else begin
                            r_start <= 1'b1;
                            r_state <= S_EXPAND;
                        end
                    end
                end
                S_EXPAND: begin
                    if (expand_done) r_state <= S_FETCH;
                end
                S_FETCH: begin
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    r_st    <= n_st;
                    r_round <= r_round + 4'd1;
                    if (last) r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_load) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_in.ready   = (r_state == S_IDLE);
    assign m_out.valid  = r_out_v;
    assign m_out.data   = r_out;
endmodule

### hw/rtl/aes_key_exp.sv
// aes key schedule sequencer: writes one round key word per cycle
// depends on aes_pkg
module aes_key_exp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [1:0]           i_key_size,
    input  logic [255:0]         i_key,
    output aes_pkg::t_rk_wr      o_wr,
    output logic                 o_done
);
    import aes_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_LOAD, S_EXP} t_state;

    t_state      r_state;
    t_rk_addr    r_idx;
    t_rk_addr    r_total;
    logic [2:0]  r_cnt;      // position of i within nk
    logic [3:0]  r_nk;
    logic [7:0]  r_rc;
    // last eight words kept in a shift line; w[i-1] at tap 0, w[i-nk] at tap nk-1
    logic [31:0] r_hist [8];
    logic        r_done;

    logic [31:0] rot, t, w_new;
    logic [3:0]  nk_sel;

    always_comb begin
        nk_sel = (i_key_size == KS_128) ? 4'd4 : (i_key_size == KS_192) ? 4'd6 : 4'd8;
        rot = {r_hist[0][23:0], r_hist[0][31:24]};
        if (r_cnt == 3'd0) begin
            t = sub_word(rot) ^ {r_rc, 24'h0};
        end else if (r_nk == 4'd8 && r_cnt == 3'd4) begin
            t = sub_word(r_hist[0]);
        end else begin
            t = r_hist[0];
        end
        w_new = r_hist[r_nk[2:0] - 3'd1] ^ t;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            o_wr.we <= 1'b0;
        end else begin
            o_wr.we <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_done  <= 1'b0;
                        r_nk    <= nk_sel;
                        r_total <= t_rk_addr'(4 * (nk_sel + 4'd7));
                        r_idx   <= '0;
                        r_rc    <= 8'h01;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    o_wr.we   <= 1'b1;
                    o_wr.addr <= r_idx;
                    o_wr.data <= i_key[255 - 32 * r_idx[2:0] -: 32];
                    for (int k = 7; k > 0; k--) r_hist[k] <= r_hist[k-1];
                    r_hist[0] <= i_key[255 - 32 * r_idx[2:0] -: 32];
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == t_rk_addr'(r_nk - 4'd1)) begin
                        r_cnt   <= '0;
                        r_state <= S_EXP;
                    end
                end
                S_EXP: begin
                    o_wr.we   <= 1'b1;
                    o_wr.addr <= r_idx;
                    o_wr.data <= w_new;
                    for (int k = 7; k > 0; k--) r_hist[k] <= r_hist[k-1];
                    r_hist[0] <= w_new;
                    if (r_cnt == 3'd0) r_rc <= xtime(r_rc);
                    r_cnt <= (r_cnt == 3'(r_nk - 4'd1)) ? 3'd0 : r_cnt + 3'd1;
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == r_total - 1'b1) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
endmodule
